### src/bucketize_one_hot_defines.svh
// ----------------------------------------------------------------------------
// Bucketizer assertion macros
// Helpers for the concurrent checks in the bucketizer sequencer.
// ----------------------------------------------------------------------------
`ifndef BUCKETIZE_ONE_HOT_DEFINES_SVH
`define BUCKETIZE_ONE_HOT_DEFINES_SVH

// Check that is switched off while reset is held.
`define BKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is held.
`define BKT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bkt_pkg.sv
// ----------------------------------------------------------------------------
// Bucketizer package
// Command codes, sequencer states, field widths and the decoded command struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bkt_pkg;

  // Field widths of the stream payloads.
  localparam int CMD_W     = 2;
  localparam int COLUMN_W  = 3;
  localparam int SLOT_W    = 4;
  localparam int ECOUNT_W  = 5;
  localparam int SAMPLE_W  = 32;
  localparam int BUCKET_W  = 5;
  localparam int POS_W     = 8;

  // Command codes carried in tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_EDGE  = 2'd0,
    CMD_WR_COUNT = 2'd1,
    CMD_CLASSIFY = 2'd2
  } cmd_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Decoded, qualified input transaction.
  typedef struct packed {
    logic wr_edge;
    logic wr_count;
    logic classify;
  } cmd_dec_t;

endpackage

### src/bkt_edge_ram.sv
// ----------------------------------------------------------------------------
// Bucketizer edge memory
// Boundary storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkt_edge_ram #(
  parameter int DEPTH      = 128,
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [VALUE_BITS-1:0]                 wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [VALUE_BITS-1:0]                 rd_data
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/bkt_count_table.sv
// ----------------------------------------------------------------------------
// Bucketizer edge count table
// Per-column edge counts, reset to one, with two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkt_count_table #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_EDGES   = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  bkt_pkg::cmd_dec_t                              dec,
  input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] wr_col,
  input  logic [bkt_pkg::ECOUNT_W-1:0]                   wr_count,
  input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] rd_a_col,
  output logic [$clog2(MAX_EDGES+1)-1:0]                 rd_a_count,
  input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] rd_b_col,
  output logic [$clog2(MAX_EDGES+1)-1:0]                 rd_b_count
);

  localparam int NW = $clog2(MAX_EDGES + 1);

  logic [NW-1:0] count_r [MAX_COLUMNS];
  logic [NW-1:0] wr_clamped;
  logic [NW-1:0] rd_a_r;
  logic [NW-1:0] rd_b_r;

  // A count of zero stores as one; counts above the table depth saturate.
  always_comb begin
    if (wr_count == '0) begin
      wr_clamped = NW'(1);
    end else if (32'(wr_count) > MAX_EDGES) begin
      wr_clamped = NW'(MAX_EDGES);
    end else begin
      wr_clamped = NW'(wr_count);
    end
  end

  // Count storage; every column starts with a single edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        count_r[c] <= NW'(1);
      end
    end else if (dec.wr_count) begin
      count_r[wr_col] <= wr_clamped;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rd_a_r <= count_r[rd_a_col];
    rd_b_r <= count_r[rd_b_col];
  end

  assign rd_a_count = rd_a_r;
  assign rd_b_count = rd_b_r;

endmodule

### src/bkt_seq.sv
// ----------------------------------------------------------------------------
// Bucketizer sequencer
// Walks a column's edges through one shared comparator pair and sums the offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bucketize_one_hot_defines.svh"

module bkt_seq #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_EDGES   = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  bkt_pkg::cmd_dec_t                              dec,
  input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] in_col,
  input  logic [VALUE_BITS-1:0]                          in_key,
  output logic                                           in_ready,
  output logic [((MAX_COLUMNS * MAX_EDGES > 1) ?
                 $clog2(MAX_COLUMNS * MAX_EDGES) : 1)-1:0] edge_rd_addr,
  input  logic [VALUE_BITS-1:0]                          edge_rd_data,
  input  logic [$clog2(MAX_EDGES+1)-1:0]                 cnt_a,
  output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] cnt_b_col,
  input  logic [$clog2(MAX_EDGES+1)-1:0]                 cnt_b,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [bkt_pkg::BUCKET_W-1:0]                   out_bucket,
  output logic [bkt_pkg::POS_W-1:0]                      out_position
);

  localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int AW   = (MAX_COLUMNS * MAX_EDGES > 1) ?
                        $clog2(MAX_COLUMNS * MAX_EDGES) : 1;
  localparam int NW   = $clog2(MAX_EDGES + 1);
  localparam int MAXI = (MAX_EDGES > MAX_COLUMNS) ? MAX_EDGES : MAX_COLUMNS;
  localparam int IW   = $clog2(MAXI + 1);
  localparam int PW   = bkt_pkg::POS_W;

  bkt_pkg::state_t st_r, st_nxt;

  logic [CW-1:0]         col_r;
  logic [VALUE_BITS-1:0] key_r;
  logic [NW-1:0]         n_r;
  logic [IW-1:0]         i_r;
  logic                  edge_pend_r;
  logic                  cnt_pend_r;
  logic [NW-1:0]         lo_r;
  logic [NW-1:0]         hi_r;
  logic [PW-1:0]         off_r;
  logic                  out_valid_r;
  logic [bkt_pkg::BUCKET_W-1:0] out_bucket_r;
  logic [PW-1:0]         out_position_r;

  logic          edge_issue;
  logic          cnt_issue;
  logic          out_free;
  logic          out_load;
  logic          cmp_lt;
  logic          cmp_le;
  logic [NW:0]   mid_sum;
  logic [NW-1:0] bucket;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bkt_pkg::ST_IDLE: begin
        if (dec.classify) begin
          st_nxt = bkt_pkg::ST_LOAD;
        end
      end
      bkt_pkg::ST_LOAD: begin
        st_nxt = bkt_pkg::ST_SCAN;
      end
      bkt_pkg::ST_SCAN: begin
        if (!edge_issue && !cnt_issue) begin
          st_nxt = bkt_pkg::ST_DONE;
        end
      end
      bkt_pkg::ST_DONE: begin
        if (out_free) begin
          st_nxt = bkt_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = bkt_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs: input ready, read issue for edges and lower-column counts, and result load.
  always_comb begin
    in_ready   = 1'b0;
    edge_issue = 1'b0;
    cnt_issue  = 1'b0;
    out_load   = 1'b0;
    unique case (st_r)
      bkt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      bkt_pkg::ST_LOAD: begin
      end
      bkt_pkg::ST_SCAN: begin
        edge_issue = (i_r < IW'(n_r));
        cnt_issue  = (i_r < IW'(col_r));
      end
      bkt_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign out_free     = !out_valid_r || out_ready;
  assign edge_rd_addr = AW'(col_r) * AW'(MAX_EDGES) + AW'(i_r);
  assign cnt_b_col    = CW'(i_r);

  // Shared comparator pair: one stored edge against the sample key.
  assign cmp_lt = $signed(edge_rd_data) < $signed(key_r);
  assign cmp_le = $signed(edge_rd_data) <= $signed(key_r);

  // Bucket is the floor of the mean of the two counts.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign bucket  = mid_sum[NW:1];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= bkt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (dec.classify) begin
      col_r <= in_col;
      key_r <= in_key;
    end
    if (st_r == bkt_pkg::ST_LOAD) begin
      n_r         <= cnt_a;
      i_r         <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      off_r       <= '0;
      edge_pend_r <= 1'b0;
      cnt_pend_r  <= 1'b0;
    end else if (st_r == bkt_pkg::ST_SCAN) begin
      edge_pend_r <= edge_issue;
      cnt_pend_r  <= cnt_issue;
      if (edge_issue || cnt_issue) begin
        i_r <= i_r + IW'(1);
      end
      if (edge_pend_r) begin
        lo_r <= lo_r + NW'(cmp_lt);
        hi_r <= hi_r + NW'(cmp_le);
      end
      if (cnt_pend_r) begin
        off_r <= off_r + PW'(cnt_b) + PW'(1);
      end
    end
    if (out_load) begin
      out_bucket_r   <= bkt_pkg::BUCKET_W'(bucket);
      out_position_r <= off_r + PW'(bucket);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_bucket   = out_bucket_r;
  assign out_position = out_position_r;

  // Checks.
  `BKT_ASSERT_RST(a_reset_idle, !rst_n |=> (st_r == bkt_pkg::ST_IDLE) && !out_valid_r, "reset did not clear sequencer")
  `BKT_ASSERT(a_lo_le_hi, (st_r == bkt_pkg::ST_DONE) |-> (lo_r <= hi_r), "strict count exceeds inclusive count")
  `BKT_ASSERT(a_hi_le_n, (st_r == bkt_pkg::ST_DONE) |-> (hi_r <= n_r), "inclusive count exceeds edge count")
  `BKT_ASSERT(a_scan_bound, (st_r == bkt_pkg::ST_SCAN) |-> (i_r <= IW'(MAXI)), "scan index overran")
  `BKT_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(st_r == bkt_pkg::ST_DONE), "result raised outside done")

endmodule

### src/bucketize_one_hot.sv
// ----------------------------------------------------------------------------
// Bucketizer with one-hot position
// Per-column feature bucketizer returning bucket and flat one-hot index.
// ----------------------------------------------------------------------------
// Load transactions (write boundary, write edge count) do not stall the input. A
// classify transaction keeps the input stalled until its result is loaded into
// the output register; the next transaction is accepted once the sequencer is
// back in idle. The steps are:
//   - the column's edge count is fetched;
//   - the edges and the lower-column counts are read, up to one of each per cycle,
//     through the shared comparator pair and the edge memory read port, with the
//     offset of the lower columns summed in the same pass;
//   - the last registered read is retired;
//   - the result is formed;
//   - the sequencer returns to idle, where the next transaction is accepted.
// The result sits in an output register, so a new transaction can be accepted
// while it waits. A later result that finds the register still full holds the
// sequencer until the register drains. Edges are compared as signed values.
// Buckets are right-inclusive, and a run of equal edges is split in the middle.
`timescale 1ns / 1ps

module bucketize_one_hot #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_EDGES   = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: column[2:0], slot[6:3], edge_count[11:7], sample[43:12], zero pad.
  input  logic [47:0] in_tdata,
  // tuser: cmd[1:0].
  input  logic [1:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: bucket[4:0], position[12:5], zero pad.
  output logic [15:0] out_tdata
);

  localparam int DEPTH = MAX_COLUMNS * MAX_EDGES;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(MAX_EDGES + 1);
  localparam int XW    = VALUE_BITS + bkt_pkg::SAMPLE_W;

  logic [bkt_pkg::COLUMN_W-1:0] in_column;
  logic [bkt_pkg::SLOT_W-1:0]   in_slot;
  logic [bkt_pkg::ECOUNT_W-1:0] in_edge_count;
  logic [bkt_pkg::SAMPLE_W-1:0] in_sample;
  bkt_pkg::cmd_t                in_cmd;

  logic                 in_acc;
  logic                 col_ok;
  logic                 slot_ok;
  bkt_pkg::cmd_dec_t    dec;
  logic [CW-1:0]        col_idx;
  logic [XW-1:0]        sample_ext;
  logic [VALUE_BITS-1:0] key;
  logic [AW-1:0]        edge_wr_addr;
  logic [AW-1:0]        edge_rd_addr;
  logic [VALUE_BITS-1:0] edge_rd_data;
  logic [NW-1:0]        cnt_a;
  logic [CW-1:0]        cnt_b_col;
  logic [NW-1:0]        cnt_b;
  logic [bkt_pkg::BUCKET_W-1:0] out_bucket;
  logic [bkt_pkg::POS_W-1:0]    out_position;

  // Unpack the input transaction.
  assign in_column     = in_tdata[2:0];
  assign in_slot       = in_tdata[6:3];
  assign in_edge_count = in_tdata[11:7];
  assign in_sample     = in_tdata[43:12];
  assign in_cmd        = bkt_pkg::cmd_t'(in_tuser);

  // Qualify the command; out-of-range columns, slots and unknown codes drop.
  assign in_acc  = in_tvalid && in_tready;
  assign col_ok  = 32'(in_column) < MAX_COLUMNS;
  assign slot_ok = 32'(in_slot) < MAX_EDGES;
  assign col_idx = CW'(in_column);

  always_comb begin
    dec = '0;
    unique case (in_cmd)
      bkt_pkg::CMD_WR_EDGE:  dec.wr_edge  = in_acc && col_ok && slot_ok;
      bkt_pkg::CMD_WR_COUNT: dec.wr_count = in_acc && col_ok;
      bkt_pkg::CMD_CLASSIFY: dec.classify = in_acc && col_ok;
      default: begin
      end
    endcase
  end

  // Low VALUE_BITS bits of the zero-extended sample, read as signed.
  assign sample_ext   = {{VALUE_BITS{1'b0}}, in_sample};
  assign key          = sample_ext[VALUE_BITS-1:0];
  assign edge_wr_addr = AW'(col_idx) * AW'(MAX_EDGES) + AW'(in_slot);

  bkt_edge_ram #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (dec.wr_edge),
    .wr_addr (edge_wr_addr),
    .wr_data (key),
    .rd_addr (edge_rd_addr),
    .rd_data (edge_rd_data)
  );

  bkt_count_table #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_EDGES   (MAX_EDGES)
  ) u_count_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec        (dec),
    .wr_col     (col_idx),
    .wr_count   (in_edge_count),
    .rd_a_col   (col_idx),
    .rd_a_count (cnt_a),
    .rd_b_col   (cnt_b_col),
    .rd_b_count (cnt_b)
  );

  bkt_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_EDGES   (MAX_EDGES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .dec          (dec),
    .in_col       (col_idx),
    .in_key       (key),
    .in_ready     (in_tready),
    .edge_rd_addr (edge_rd_addr),
    .edge_rd_data (edge_rd_data),
    .cnt_a        (cnt_a),
    .cnt_b_col    (cnt_b_col),
    .cnt_b        (cnt_b),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_bucket   (out_bucket),
    .out_position (out_position)
  );

  // Pack the result transaction.
  assign out_tdata = {3'b000, out_position, out_bucket};

endmodule
